// File: design/assert_macros.svh
// assertion helpers shared by the parser and the output register
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// antecedent at one edge implies the consequent at the same edge
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// antecedent at one edge implies the consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: design/cpd_pkg.sv
package cpd_pkg;

    // register map, index is paddr[2]
    localparam int unsigned ADDR_W = 3;
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    localparam logic [7:0] START_MARKER_RST = 8'hAA;
    localparam logic [7:0] END_MARKER_RST   = 8'hBB;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // frame status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADCRC = 2'd1;
    localparam logic [1:0] ST_BADEND = 2'd2;

    localparam int unsigned OUT_DATA_W = 40;

    typedef enum logic [6:0] {
        PH_START   = 7'b0000001,
        PH_LENGTH  = 7'b0000010,
        PH_COMMAND = 7'b0000100,
        PH_PAYLOAD = 7'b0001000,
        PH_CRC_HI  = 7'b0010000,
        PH_CRC_LO  = 7'b0100000,
        PH_END     = 7'b1000000
    } phase_t;

    // one result item
    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_command;
        logic [7:0] frame_length;
        logic [1:0] frame_status;
    } result_t;

    // marker settings handed from the register block
    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
    } cfg_t;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            v = v[15] ? ({v[14:0], 1'b0} ^ CRC_POLY) : {v[14:0], 1'b0};
        end
        return v;
    endfunction

endpackage

// File: design/cpd_regs.sv
module cpd_regs
    import cpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [7:0] start_reg;
    logic [7:0] start_next;
    logic [7:0] end_reg;
    logic [7:0] end_next;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    // register writes, byte offset within a word is ignored
    always_comb begin
        start_next = start_reg;
        end_next   = end_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_START_MARKER: start_next = pwdata[7:0];
                REG_END_MARKER:   end_next   = pwdata[7:0];
                default:          start_next = start_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= START_MARKER_RST;
            end_reg   <= END_MARKER_RST;
        end else begin
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

    // read back
    always_comb begin
        case (reg_sel)
            REG_START_MARKER: prdata = {24'd0, start_reg};
            REG_END_MARKER:   prdata = {24'd0, end_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.start_marker = start_reg;
    assign cfg.end_marker   = end_reg;

endmodule

// File: design/cpd_parser.sv
`include "assert_macros.svh"

module cpd_parser
    import cpd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       out_free,
    output logic       res_load,
    output result_t    res
);

    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] in_byte_reg;
    logic       adv;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  len_reg;
    logic [7:0]  len_next;
    logic [7:0]  cmd_reg;
    logic [7:0]  cmd_next;
    logic [7:0]  cnt_reg;
    logic [7:0]  cnt_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] rxcrc_reg;
    logic [15:0] rxcrc_next;
    logic [15:0] crc_upd;
    logic [7:0]  cnt_inc;
    logic        res_vld;

    // input register, drained whenever the result side can take an item
    assign adv      = in_vld_reg & out_free;
    assign s_tready = ~in_vld_reg | adv;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
        end else if (adv) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    assign crc_upd = crc16_byte(crc_reg, in_byte_reg);
    assign cnt_inc = cnt_reg + 8'd1;

    // frame parser, one byte per advance
    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        rxcrc_next = rxcrc_reg;
        res_vld    = 1'b0;
        res.kind          = KIND_PAYLOAD;
        res.payload_byte  = 8'd0;
        res.payload_index = 8'd0;
        res.frame_command = cmd_reg;
        res.frame_length  = len_reg;
        res.frame_status  = ST_OK;
        case (phase_reg)
            PH_LENGTH: begin
                len_next   = in_byte_reg;
                crc_next   = crc_upd;
                phase_next = PH_COMMAND;
            end
            PH_COMMAND: begin
                cmd_next   = in_byte_reg;
                crc_next   = crc_upd;
                cnt_next   = 8'd0;
                phase_next = (len_reg != 8'd0) ? PH_PAYLOAD : PH_CRC_HI;
            end
            PH_PAYLOAD: begin
                crc_next          = crc_upd;
                res_vld           = 1'b1;
                res.payload_byte  = in_byte_reg;
                res.payload_index = cnt_reg;
                cnt_next          = cnt_inc;
                if (cnt_inc == len_reg) begin
                    phase_next = PH_CRC_HI;
                end
            end
            PH_CRC_HI: begin
                rxcrc_next = {in_byte_reg, 8'd0};
                phase_next = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                rxcrc_next = {rxcrc_reg[15:8], in_byte_reg};
                phase_next = PH_END;
            end
            PH_END: begin
                res_vld  = 1'b1;
                res.kind = KIND_STATUS;
                if (in_byte_reg != cfg.end_marker) begin
                    res.frame_status = ST_BADEND;
                end else if (crc_reg != rxcrc_reg) begin
                    res.frame_status = ST_BADCRC;
                end else begin
                    res.frame_status = ST_OK;
                end
                phase_next = PH_START;
            end
            default: begin
                // hunting for the start marker
                phase_next = PH_START;
                if (in_byte_reg == cfg.start_marker) begin
                    crc_next   = CRC_INIT;
                    phase_next = PH_LENGTH;
                end
            end
        endcase
    end

    assign res_load = adv & res_vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            len_reg   <= 8'd0;
            cmd_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            crc_reg   <= CRC_INIT;
            rxcrc_reg <= 16'd0;
        end else if (adv) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            rxcrc_reg <= rxcrc_next;
        end
    end

    // results come only from payload or end positions
    `ASSERT_IMPLY(a_res_phase, aclk, aresetn, res_load, (phase_reg == PH_PAYLOAD) || (phase_reg == PH_END))
    // payload counter stays below the announced length
    `ASSERT_IMPLY(a_cnt_range, aclk, aresetn, phase_reg == PH_PAYLOAD, cnt_reg < len_reg)
    // a status item sends the parser back to hunting
    `ASSERT_NEXT(a_end_to_start, aclk, aresetn, adv && (phase_reg == PH_END), phase_reg == PH_START)
    // crc is seeded when a frame opens
    `ASSERT_NEXT(a_crc_seed, aclk, aresetn, adv && (phase_next == PH_LENGTH), crc_reg == CRC_INIT)

endmodule

// File: design/cpd_out_reg.sv
`include "assert_macros.svh"

module cpd_out_reg
    import cpd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  result_t               res,
    output logic                  out_free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign out_free = ~vld_reg | m_tready;

    // result register valid flag
    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {6'd0, res_reg.frame_status, res_reg.frame_length,
                       res_reg.frame_command, res_reg.payload_index, res_reg.payload_byte};

    // a new result never overwrites one still waiting
    `ASSERT_IMPLY(a_no_overwrite, aclk, aresetn, load, !vld_reg || m_tready)

endmodule

// File: design/crc_packet_deframer.sv
// channel  | ports              | contents
// ---------+--------------------+------------------------------------------------
// rx in    | s_tvalid/tready    | s_tdata: rx_byte
// result   | m_tvalid/tready    | m_tdata: payload_byte, payload_index,
//          |                    |   frame_command, frame_length, frame_status;
//          |                    | m_tuser: kind
// config   | apb psel/penable   | reg 0 start_marker @0x0, reg 1 end_marker @0x4
//
// one item per cycle sustained while the result register is not stalled; a byte
// waits in the input register and any result of it is loaded into the result register.
// the byte-wide crc update and phase change sit between the two registers.
// a stalled result register stops the parser and, once the input register
// is full, s_tready drops. synchronous active-low reset, no clearing pass.
module crc_packet_deframer
    import cpd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // apb configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // received bytes
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                             // [23:16] frame_command, [31:24] frame_length,
                                             // [33:32] frame_status, [39:34] zero
    output logic                  m_tuser    // [0] kind
);

    cfg_t    cfg;
    logic    out_free;
    logic    res_load;
    result_t res;

    cpd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpd_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res)
    );

    cpd_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_load),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
